// File: hw/rtl/windowed_rms_power_meter_defines.svh
// ----------------------------------------------------------------------------
// Windowed RMS power meter assertion macros
// Shared property wrappers for the RTL checks.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RMS_POWER_METER_DEFINES_SVH
`define WINDOWED_RMS_POWER_METER_DEFINES_SVH

// same-cycle implication, held off during reset
`define WRPM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, held off during reset
`define WRPM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// File: hw/rtl/wrpm_pkg.sv
// ----------------------------------------------------------------------------
// wrpm_pkg
// Types and constants shared by the windowed RMS power meter modules.
// ----------------------------------------------------------------------------
package wrpm_pkg;

   localparam int unsigned ADC_BITS_DEF   = 12;
   localparam int unsigned COUNT_BITS_DEF = 16;
   localparam int unsigned CODE_W         = 12;
   localparam int unsigned GAIN_W         = 24;
   localparam int unsigned OFFS_W         = 32;
   localparam int unsigned CSR_IDX_W      = 3;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam int unsigned QUEUE_DEPTH    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ADC_MID  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_V_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_I_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_V_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_I_OFFSET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_P_OFFSET = 3'd5;

   localparam logic [CODE_W-1:0] ADC_MID_RST = 12'd2048;
   localparam logic [GAIN_W-1:0] GAIN_RST    = 24'd65536;

   typedef struct packed {
      logic [CODE_W-1:0] v_code;
      logic [CODE_W-1:0] i_code;
      logic              window_last;
   } req_type;

   typedef struct packed {
      logic [31:0]        v_rms;
      logic [31:0]        i_rms;
      logic signed [47:0] p_avg;
      logic [15:0]        sample_count;
      logic               count_overflow;
   } rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0]        adc_mid;
      logic [GAIN_W-1:0]        v_gain;
      logic [GAIN_W-1:0]        i_gain;
      logic signed [OFFS_W-1:0] v_offset;
      logic signed [OFFS_W-1:0] i_offset;
      logic signed [OFFS_W-1:0] p_offset;
   } cfg_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

endpackage

// File: hw/rtl/windowed_rms_power_meter.sv
// Samples: one word a cycle, save while req_stall holds a closing sample until the
// queue has room; each is registered and then added to the window sums.
// Window result: each window goes through the shared one-bit-per-cycle divider and
// square root and then the multiplier before rsp_valid rises; two windows can wait.
// Reset (synchronous, high) clears sums, queue and rsp_valid; CSRs take defaults.
// ----------------------------------------------------------------------------
// windowed_rms_power_meter
// True RMS and active power over flagged windows of paired ADC samples.
// ----------------------------------------------------------------------------
`include "windowed_rms_power_meter_defines.svh"

module windowed_rms_power_meter #(
   parameter int unsigned ADC_BITS   = wrpm_pkg::ADC_BITS_DEF,
   parameter int unsigned COUNT_BITS = wrpm_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  wrpm_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output wrpm_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wrpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wrpm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int unsigned SQW = 2*ADC_BITS + COUNT_BITS;
   localparam int unsigned EW  = 3*SQW + 1 + COUNT_BITS + 1;

   wrpm_pkg::cfg_type      cfg_ff;
   wrpm_pkg::q_status_type q_status;
   logic                   q_push, q_pop;
   logic [EW-1:0]          q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.adc_mid  <= wrpm_pkg::ADC_MID_RST;
         cfg_ff.v_gain   <= wrpm_pkg::GAIN_RST;
         cfg_ff.i_gain   <= wrpm_pkg::GAIN_RST;
         cfg_ff.v_offset <= '0;
         cfg_ff.i_offset <= '0;
         cfg_ff.p_offset <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wrpm_pkg::CSR_ADC_MID:  cfg_ff.adc_mid  <= csr_wdata[wrpm_pkg::CODE_W-1:0];
            wrpm_pkg::CSR_V_GAIN:   cfg_ff.v_gain   <= csr_wdata[wrpm_pkg::GAIN_W-1:0];
            wrpm_pkg::CSR_I_GAIN:   cfg_ff.i_gain   <= csr_wdata[wrpm_pkg::GAIN_W-1:0];
            wrpm_pkg::CSR_V_OFFSET: cfg_ff.v_offset <= $signed(csr_wdata);
            wrpm_pkg::CSR_I_OFFSET: cfg_ff.i_offset <= $signed(csr_wdata);
            wrpm_pkg::CSR_P_OFFSET: cfg_ff.p_offset <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   wrpm_front #(
      .ADC_BITS   (ADC_BITS),
      .COUNT_BITS (COUNT_BITS),
      .EW         (EW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   wrpm_queue #(
      .WIDTH (EW),
      .DEPTH (wrpm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   wrpm_back #(
      .ADC_BITS   (ADC_BITS),
      .COUNT_BITS (COUNT_BITS),
      .EW         (EW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .q_data    (q_rdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hw/rtl/wrpm_queue.sv
// ----------------------------------------------------------------------------
// wrpm_queue
// Short FIFO of finished window sums between the front and back ends.
// ----------------------------------------------------------------------------
`include "windowed_rms_power_meter_defines.svh"

module wrpm_queue #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = wrpm_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       pop_data,
   output wrpm_pkg::q_status_type status
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == (AW+1)'(DEPTH));
   assign pop_data         = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

   `WRPM_ASSERT_IMPL(a_no_push_full, clock, reset, push, !status.full)
   `WRPM_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, status.not_empty)

endmodule

// File: hw/rtl/wrpm_front.sv
// ----------------------------------------------------------------------------
// wrpm_front
// Takes sample words, removes the mid-scale code and keeps the window sums.
// ----------------------------------------------------------------------------
`include "windowed_rms_power_meter_defines.svh"

module wrpm_front #(
   parameter int unsigned ADC_BITS   = wrpm_pkg::ADC_BITS_DEF,
   parameter int unsigned COUNT_BITS = wrpm_pkg::COUNT_BITS_DEF,
   parameter int unsigned EW         = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  wrpm_pkg::req_type      req_data,
   input  wrpm_pkg::cfg_type      cfg,
   input  wrpm_pkg::q_status_type q_status,
   output logic                   q_push,
   output logic [EW-1:0]          q_data
);

   localparam int unsigned AB  = ADC_BITS;
   localparam int unsigned CB  = COUNT_BITS;
   localparam int unsigned SQW = 2*AB + CB;
   localparam int unsigned SPW = SQW + 1;
   localparam int unsigned CW  = (AB < wrpm_pkg::CODE_W) ? AB : wrpm_pkg::CODE_W;

   typedef struct packed {
      logic [SQW-1:0]        sum_v;
      logic [SQW-1:0]        sum_i;
      logic signed [SPW-1:0] sum_p;
      logic [CB-1:0]         count;
      logic                  dropped;
   } win_type;

   logic                  s1_valid_ff;
   logic signed [AB:0]    dv_ff, di_ff;
   logic                  last_ff;
   logic [SQW-1:0]        sum_v_ff, sum_i_ff, sum_v_in, sum_i_in;
   logic signed [SPW-1:0] sum_p_ff, sum_p_in;
   logic [CB-1:0]         count_ff, count_in;
   logic                  dropped_ff, dropped_in;

   logic [AB-1:0]           mid_ab, v_ab, i_ab;
   logic signed [2*AB+1:0]  sq_v, sq_i, prod;
   logic                    s1_adv, accept;
   win_type                 win;

   assign mid_ab = AB'(cfg.adc_mid[CW-1:0]);
   assign v_ab   = AB'(req_data.v_code[CW-1:0]);
   assign i_ab   = AB'(req_data.i_code[CW-1:0]);

   // a closing sample waits until the queue has room
   assign s1_adv    = s1_valid_ff && (!last_ff || !q_status.full);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   assign sq_v = dv_ff * dv_ff;
   assign sq_i = di_ff * di_ff;
   assign prod = dv_ff * di_ff;

   always_comb begin
      sum_v_in   = sum_v_ff;
      sum_i_in   = sum_i_ff;
      sum_p_in   = sum_p_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (count_ff != {CB{1'b1}}) begin
         sum_v_in = sum_v_ff + SQW'(sq_v[2*AB-1:0]);
         sum_i_in = sum_i_ff + SQW'(sq_i[2*AB-1:0]);
         sum_p_in = sum_p_ff + SPW'($signed(prod[2*AB:0]));
         count_in = count_ff + 1'b1;
      end else begin
         dropped_in = 1'b1;
      end
   end

   assign win.sum_v   = sum_v_in;
   assign win.sum_i   = sum_i_in;
   assign win.sum_p   = sum_p_in;
   assign win.count   = count_in;
   assign win.dropped = dropped_in;
   assign q_data      = win;
   assign q_push      = s1_adv && last_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         dv_ff   <= $signed({1'b0, v_ab}) - $signed({1'b0, mid_ab});
         di_ff   <= $signed({1'b0, i_ab}) - $signed({1'b0, mid_ab});
         last_ff <= req_data.window_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sum_v_ff    <= '0;
         sum_i_ff    <= '0;
         sum_p_ff    <= '0;
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept || (s1_valid_ff && !s1_adv);
         if (s1_adv) begin
            if (last_ff) begin
               // close the window and start the next one empty
               sum_v_ff   <= '0;
               sum_i_ff   <= '0;
               sum_p_ff   <= '0;
               count_ff   <= '0;
               dropped_ff <= 1'b0;
            end else begin
               sum_v_ff   <= sum_v_in;
               sum_i_ff   <= sum_i_in;
               sum_p_ff   <= sum_p_in;
               count_ff   <= count_in;
               dropped_ff <= dropped_in;
            end
         end
      end
   end

   `WRPM_ASSERT_IMPL(a_empty_not_dropped, clock, reset, count_ff == '0, !dropped_ff)

endmodule

// File: hw/rtl/wrpm_back.sv
// ----------------------------------------------------------------------------
// wrpm_back
// Turns one window of sums into RMS and power results with shared
// divider, square root and multiplier units.
// ----------------------------------------------------------------------------
`include "windowed_rms_power_meter_defines.svh"

module wrpm_back #(
   parameter int unsigned ADC_BITS   = wrpm_pkg::ADC_BITS_DEF,
   parameter int unsigned COUNT_BITS = wrpm_pkg::COUNT_BITS_DEF,
   parameter int unsigned EW         = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wrpm_pkg::cfg_type      cfg,
   input  wrpm_pkg::q_status_type q_status,
   output logic                   q_pop,
   input  logic [EW-1:0]          q_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output wrpm_pkg::rsp_type      rsp_data
);

   localparam int unsigned AB   = ADC_BITS;
   localparam int unsigned CB   = COUNT_BITS;
   localparam int unsigned SQW  = 2*AB + CB;
   localparam int unsigned SPW  = SQW + 1;
   localparam int unsigned MA   = (2*AB > 24) ? 2*AB : 24;
   localparam int unsigned MW   = MA + 24;
   localparam int unsigned TW   = MA + 10;
   localparam int unsigned PMW  = MA + 17;
   localparam int unsigned PW   = (MA + 19 > 49) ? MA + 19 : 49;
   localparam int unsigned CNTW = $clog2(SQW + 1);

   typedef struct packed {
      logic [SQW-1:0]        sum_v;
      logic [SQW-1:0]        sum_i;
      logic signed [SPW-1:0] sum_p;
      logic [CB-1:0]         count;
      logic                  dropped;
   } win_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_V, ST_SQR_V, ST_DIV_I, ST_SQR_I, ST_DIV_P,
      ST_MUL_V, ST_MUL_I, ST_MUL_G, ST_MUL_L, ST_MUL_H, ST_SUM, ST_FIN, ST_OUT
   } state_type;

   state_type state_ff;
   win_type   q_win;

   logic [SQW-1:0]    sum_i_ff, mag_ff;
   logic              neg_ff, ovf_ff;
   logic [CB-1:0]     n_ff;
   logic [SQW-1:0]    dq_ff;
   logic [CB-1:0]     rem_ff;
   logic [CNTW-1:0]   cnt_ff;
   logic [2*AB-1:0]   sx_ff;
   logic [AB-1:0]     root_ff, rv_ff, ri_ff;
   logic [AB:0]       srem_ff;
   logic [MA-1:0]     m_ff;
   logic [MW-1:0]     mul_ff, lo_ff;
   logic [23:0]       ghi_ff;
   logic [PMW-1:0]    pm_ff;
   logic              rsp_valid_ff;
   wrpm_pkg::rsp_type rsp_data_ff;

   // divider step
   logic [CB:0]     shifted_d, diff_d;
   logic            dge;
   logic [CB-1:0]   rem_in;
   logic [SQW-1:0]  quot_in;
   // square root step
   logic [AB+2:0]   shifted_s, trial_s, diff_s;
   logic            sge;
   logic [AB:0]     srem_in;
   logic [AB-1:0]   root_in;
   // multiplier and result
   logic [MA-1:0]   mul_a;
   logic [23:0]     mul_b;
   logic [MW-1:0]   mul_res;
   logic [MA+24:0]  pm_sum;
   logic [PMW-1:0]  pm_in;
   logic signed [PW-1:0] p_s, p_t;
   logic [PW-48:0]  p_hi;
   logic signed [47:0] p_avg_in;
   logic            div_done, sqr_done;

   function automatic logic [31:0] rms_clamp(input logic [MA+7:0] scaled,
                                             input logic signed [31:0] offs);
      logic signed [TW-1:0] t;
      t = $signed({2'b00, scaled}) + TW'(offs);
      if (t[TW-1]) begin
         return '0;
      end else if (|t[TW-2:32]) begin
         return '1;
      end
      return t[31:0];
   endfunction

   assign q_win     = q_data;
   assign q_pop     = (state_ff == ST_IDLE) && q_status.not_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign div_done = (cnt_ff == CNTW'(SQW - 1));
   assign sqr_done = (cnt_ff == CNTW'(AB - 1));

   // restoring division, one quotient bit a cycle
   assign shifted_d = {rem_ff, dq_ff[SQW-1]};
   assign diff_d    = shifted_d - {1'b0, n_ff};
   assign dge       = (shifted_d >= {1'b0, n_ff});
   assign rem_in    = dge ? diff_d[CB-1:0] : shifted_d[CB-1:0];
   assign quot_in   = {dq_ff[SQW-2:0], dge};

   // digit-by-digit square root, one root bit a cycle
   assign shifted_s = {srem_ff, sx_ff[2*AB-1:2*AB-2]};
   assign trial_s   = {1'b0, root_ff, 2'b01};
   assign diff_s    = shifted_s - trial_s;
   assign sge       = (shifted_s >= trial_s);
   assign srem_in   = sge ? diff_s[AB:0] : shifted_s[AB:0];
   assign root_in   = {root_ff[AB-2:0], sge};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_V: begin
            mul_a = MA'(rv_ff);
            mul_b = cfg.v_gain;
         end
         ST_MUL_I: begin
            mul_a = MA'(ri_ff);
            mul_b = cfg.i_gain;
         end
         ST_MUL_G: begin
            mul_a = MA'(cfg.v_gain);
            mul_b = cfg.i_gain;
         end
         ST_MUL_L: begin
            mul_a = m_ff;
            mul_b = mul_ff[23:0];
         end
         ST_MUL_H: begin
            mul_a = m_ff;
            mul_b = ghi_ff;
         end
         default: begin
         end
      endcase
   end

   assign mul_res = {{24{1'b0}}, mul_a} * {{MA{1'b0}}, mul_b};

   // high partial product plus carried-in low part, then drop 32 bits in total
   assign pm_sum = {1'b0, mul_ff} + (MA+25)'(lo_ff[MW-1:24]);
   assign pm_in  = pm_sum[MA+24:8];

   assign p_s  = neg_ff ? -$signed(PW'(pm_ff)) : $signed(PW'(pm_ff));
   assign p_t  = p_s + PW'(cfg.p_offset);
   assign p_hi = p_t[PW-1:47];

   always_comb begin
      if ((&p_hi) || !(|p_hi)) begin
         p_avg_in = p_t[47:0];
      end else if (p_t[PW-1]) begin
         p_avg_in = {1'b1, {47{1'b0}}};
      end else begin
         p_avg_in = {1'b0, {47{1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (q_status.not_empty) begin
                  sum_i_ff <= q_win.sum_i;
                  mag_ff   <= q_win.sum_p[SPW-1] ? SQW'(-q_win.sum_p) : SQW'(q_win.sum_p);
                  neg_ff   <= q_win.sum_p[SPW-1];
                  n_ff     <= q_win.count;
                  ovf_ff   <= q_win.dropped;
                  dq_ff    <= q_win.sum_v;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV_V;
               end
            end
            ST_DIV_V, ST_DIV_I, ST_DIV_P: begin
               dq_ff  <= quot_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (div_done) begin
                  cnt_ff  <= '0;
                  sx_ff   <= quot_in[2*AB-1:0];
                  root_ff <= '0;
                  srem_ff <= '0;
                  m_ff    <= MA'(quot_in[2*AB-1:0]);
                  priority case (state_ff)
                     ST_DIV_V: state_ff <= ST_SQR_V;
                     ST_DIV_I: state_ff <= ST_SQR_I;
                     default:  state_ff <= ST_MUL_V;
                  endcase
               end
            end
            ST_SQR_V, ST_SQR_I: begin
               sx_ff   <= sx_ff << 2;
               srem_ff <= srem_in;
               root_ff <= root_in;
               cnt_ff  <= cnt_ff + 1'b1;
               if (sqr_done) begin
                  cnt_ff <= '0;
                  rem_ff <= '0;
                  if (state_ff == ST_SQR_V) begin
                     rv_ff    <= root_in;
                     dq_ff    <= sum_i_ff;
                     state_ff <= ST_DIV_I;
                  end else begin
                     ri_ff    <= root_in;
                     dq_ff    <= mag_ff;
                     state_ff <= ST_DIV_P;
                  end
               end
            end
            ST_MUL_V: begin
               mul_ff   <= mul_res;
               state_ff <= ST_MUL_I;
            end
            ST_MUL_I: begin
               mul_ff            <= mul_res;
               rsp_data_ff.v_rms <= rms_clamp(mul_ff[MA+23:16], cfg.v_offset);
               state_ff          <= ST_MUL_G;
            end
            ST_MUL_G: begin
               mul_ff            <= mul_res;
               rsp_data_ff.i_rms <= rms_clamp(mul_ff[MA+23:16], cfg.i_offset);
               state_ff          <= ST_MUL_L;
            end
            ST_MUL_L: begin
               ghi_ff   <= mul_ff[47:24];
               mul_ff   <= mul_res;
               state_ff <= ST_MUL_H;
            end
            ST_MUL_H: begin
               lo_ff    <= mul_ff;
               mul_ff   <= mul_res;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               pm_ff    <= pm_in;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               rsp_data_ff.p_avg          <= p_avg_in;
               rsp_data_ff.sample_count   <= 16'(n_ff);
               rsp_data_ff.count_overflow <= ovf_ff;
               rsp_valid_ff               <= 1'b1;
               state_ff                   <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `WRPM_ASSERT_IMPL(a_count_nonzero, clock, reset, state_ff == ST_FIN, n_ff != '0)
   `WRPM_ASSERT_NEXT(a_fin_shows_result, clock, reset, state_ff == ST_FIN, rsp_valid_ff)

endmodule
